@@ rtl/core/sparse_segment_key_sorter_defines.svh @@
// assertion macros for the sparse segment key sorter
// used by the rtl top level, which asserts; no other dependencies
`ifndef SPARSE_SEGMENT_KEY_SORTER_DEFINES_SVH
`define SPARSE_SEGMENT_KEY_SORTER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SSKS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SSKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/ssks_pkg.sv @@
// shared types, constants and key compare for the sparse segment key sorter
// no dependencies
package ssks_pkg;

	localparam int unsigned IDX_W = 32;
	localparam int unsigned VAL_W = 64;
	// arrival sequence number, enough for the largest supported segment
	localparam int unsigned SEQ_W = 6;

	typedef struct packed {
		logic [IDX_W-1:0] major;
		logic [IDX_W-1:0] minor;
		logic [VAL_W-1:0] re;
		logic [VAL_W-1:0] im;
		logic [SEQ_W-1:0] seq;
	} entry_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SWAP,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     mode;
	} cell_ctrl_t;

	// what one cell shows its neighbors
	typedef struct packed {
		entry_t entry;
		logic   valid;
		logic   gt;
		logic   swap;
	} cell_link_t;

	localparam logic MODE_MINOR = 1'b0;
	localparam logic MODE_MAJOR_MINOR = 1'b1;

	// true when a must come strictly after b; arrival order breaks ties
	function automatic logic ssks_after(entry_t a, entry_t b, logic mode);
		logic minor_after;
		minor_after = (a.minor > b.minor) || ((a.minor == b.minor) && (a.seq > b.seq));
		if ((mode == MODE_MAJOR_MINOR) && (a.major != b.major)) begin
			return a.major > b.major;
		end
		return minor_after;
	endfunction

endpackage

@@ rtl/core/ssks_cell.sv @@
// one sorting cell: holds an entry and moves it to or from its neighbors
// depends on ssks_pkg
module ssks_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  ssks_pkg::cell_ctrl_t ctrl,
	input  ssks_pkg::entry_t  new_entry,
	input  logic              pair_left,
	input  ssks_pkg::cell_link_t left_link,
	input  ssks_pkg::cell_link_t right_link,
	output ssks_pkg::cell_link_t link
);
	import ssks_pkg::*;

	entry_t entry_q;
	logic   valid_q;
	logic   own_gt;
	entry_t entry_d;
	logic   valid_d;

	// empty cells count as larger than anything; the or keeps gt monotone
	assign own_gt = !valid_q || ssks_after(entry_q, new_entry, ctrl.mode);

	assign link.entry = entry_q;
	assign link.valid = valid_q;
	assign link.gt    = left_link.gt | own_gt;
	assign link.swap  = pair_left && valid_q && right_link.valid &&
		ssks_after(entry_q, right_link.entry, ctrl.mode);

	always_comb begin
		entry_d = entry_q;
		valid_d = valid_q;
		case (ctrl.op)
			CELL_INSERT: begin
				if (left_link.gt) begin
					entry_d = left_link.entry;
					valid_d = left_link.valid;
				end else if (own_gt) begin
					entry_d = new_entry;
					valid_d = 1'b1;
				end
			end
			CELL_SWAP: begin
				if (link.swap) begin
					entry_d = right_link.entry;
				end else if (left_link.swap) begin
					entry_d = left_link.entry;
				end
			end
			CELL_SHIFT: begin
				entry_d = right_link.entry;
				valid_d = right_link.valid;
			end
			default: begin
				entry_d = entry_q;
				valid_d = valid_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

@@ rtl/core/sparse_segment_key_sorter.sv @@
// top level of the sparse segment key sorter: control and a chain of sorting cells
// depends on ssks_pkg, ssks_cell and sparse_segment_key_sorter_defines.svh
//
// usage:
//   s_* channel takes one entry per transaction: s_tdata holds major, minor,
//   real and imaginary words, s_tlast ends the segment. cfg_* writes key_mode
//   (0 minor index only, 1 major then minor) and is always ready.
//   each accepted entry is inserted into its sorted place in the cell chain in
//   the cycle it arrives, so a segment streams in at one entry per cycle.
//   entries beyond MAX_ENTRIES are dropped and every result of that segment
//   carries overflow in m_tuser.
//   after the last entry the chain is emptied through the output register at
//   one entry per cycle from cell 0 unless m_tready stalls; the first result
//   is registered once the state has moved on to the drain. if key_mode was
//   written while entries were held, an odd-even exchange pass re-sorts the
//   chain before the results leave. s_tready is low while the chain re-sorts
//   or results are draining, and the next segment may start while the final
//   result still waits in the output register.
//   while draining, a stalled m_tready freezes the chain and the output register.
//   reset empties the chain, clears the counters and sets key_mode to 0.
`include "sparse_segment_key_sorter_defines.svh"

module sparse_segment_key_sorter #(
	parameter int unsigned MAX_ENTRIES = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_data,    // key_mode
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,     // major_index, minor_index, value_real, value_imag
	input  logic         s_tlast,     // last
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [191:0] m_tdata,     // out_major, out_minor, out_real, out_imag
	output logic         m_tlast,     // out_last
	output logic         m_tuser      // overflow
);
	import ssks_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned PH_W  = $clog2(MAX_ENTRIES);

	typedef enum logic [1:0] {
		ST_FILL,
		ST_SORT,
		ST_DRAIN
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   remain_q;
	logic [PH_W-1:0]    phase_q;
	logic               ovf_q;
	logic               seg_ovf_q;
	logic               dirty_q;
	logic               mode_q;
	logic               m_tvalid_q;
	logic [191:0]       m_tdata_q;
	logic               m_tlast_q;
	logic               m_tuser_q;

	logic               in_acc;
	logic               cfg_acc;
	logic               full;
	logic               load;
	cell_ctrl_t         ctrl;
	entry_t             new_entry;
	cell_link_t         links [MAX_ENTRIES];
	cell_link_t         out_entry;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign s_tready  = (state_q == ST_FILL);
	assign in_acc    = s_tvalid && s_tready;
	assign full      = (count_q == CNT_W'(MAX_ENTRIES));
	assign out_entry = links[0];
	assign load      = (state_q == ST_DRAIN) && (remain_q != '0) &&
		(!m_tvalid_q || m_tready);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	always_comb begin
		new_entry.major = s_tdata[31:0];
		new_entry.minor = s_tdata[63:32];
		new_entry.re    = s_tdata[127:64];
		new_entry.im    = s_tdata[191:128];
		new_entry.seq   = SEQ_W'(count_q);
	end

	always_comb begin
		ctrl.mode = mode_q;
		ctrl.op   = CELL_HOLD;
		case (state_q)
			ST_FILL: begin
				if (in_acc && !full) begin
					ctrl.op = CELL_INSERT;
				end
			end
			ST_SORT: ctrl.op = CELL_SWAP;
			ST_DRAIN: begin
				if (load) begin
					ctrl.op = CELL_SHIFT;
				end
			end
			default: ctrl.op = CELL_HOLD;
		endcase
	end

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		cell_link_t left_link;
		cell_link_t right_link;
		logic       pair_left;

		if (i == 0) begin : g_head
			assign left_link = '0;
		end else begin : g_body
			assign left_link = links[i-1];
		end
		if (i == MAX_ENTRIES - 1) begin : g_tail
			assign right_link = '0;
		end else begin : g_inner
			assign right_link = links[i+1];
		end
		// exchange pairs alternate between even and odd starting cells
		assign pair_left = (1'(i % 2) == phase_q[0]);

		ssks_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_entry  (new_entry),
			.pair_left  (pair_left),
			.left_link  (left_link),
			.right_link (right_link),
			.link       (links[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_FILL;
			count_q    <= '0;
			remain_q   <= '0;
			phase_q    <= '0;
			ovf_q      <= 1'b0;
			seg_ovf_q  <= 1'b0;
			dirty_q    <= 1'b0;
			mode_q     <= MODE_MINOR;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tlast_q  <= 1'b0;
			m_tuser_q  <= 1'b0;
		end else begin
			if (cfg_acc) begin
				mode_q <= cfg_data;
				// entries already placed under the old order need a re-sort
				if ((count_q != '0) && !(in_acc && s_tlast)) begin
					dirty_q <= 1'b1;
				end
			end

			if (m_tvalid_q && m_tready && !load) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_FILL: begin
					if (in_acc) begin
						if (s_tlast) begin
							remain_q  <= full ? count_q : count_q + CNT_W'(1);
							seg_ovf_q <= ovf_q || full;
							count_q   <= '0;
							ovf_q     <= 1'b0;
							phase_q   <= '0;
							dirty_q   <= 1'b0;
							state_q   <= (dirty_q || (cfg_acc && count_q != '0)) ?
								ST_SORT : ST_DRAIN;
						end else if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				ST_SORT: begin
					phase_q <= phase_q + PH_W'(1);
					if (phase_q == PH_W'(MAX_ENTRIES - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (load) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {out_entry.entry.im, out_entry.entry.re,
							out_entry.entry.minor, out_entry.entry.major};
						m_tlast_q  <= (remain_q == CNT_W'(1));
						m_tuser_q  <= seg_ovf_q;
						remain_q   <= remain_q - CNT_W'(1);
						if (remain_q == CNT_W'(1)) begin
							state_q <= ST_FILL;
						end
					end
				end
				default: state_q <= ST_FILL;
			endcase
		end
	end

	`SSKS_ASSERT_NOW(a_count_in_range, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_ENTRIES), "entry count beyond capacity")
	`SSKS_ASSERT_NOW(a_head_valid, clk, arst_n, state_q == ST_DRAIN && remain_q != '0, links[0].valid, "no stored entry left to emit")
	`SSKS_ASSERT_NEXT(a_remain_step, clk, arst_n, load, remain_q == $past(remain_q) - CNT_W'(1), "remaining count did not step")
	`SSKS_ASSERT_NEXT(a_drain_done, clk, arst_n, load && remain_q == CNT_W'(1), state_q == ST_FILL && m_tvalid && m_tlast, "segment end not marked on final result")

endmodule

@@ test/sparse_segment_key_sorter_tb.sv @@
// testbench for sparse_segment_key_sorter: streams segments of sparse entries in both key
// modes and checks every sorted run against a stable insertion sort kept in the bench
// depends on ssks_pkg and the rtl top level
module sparse_segment_key_sorter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = 64;
	// worst case internal work after the last input: full re-sort pass plus drain slack
	localparam int unsigned SETTLE_CYCLES = DEPTH + 8;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_PHASES = 2;
	localparam int unsigned PHASE_ITEMS = 14;

	typedef struct {
		logic [31:0] major;
		logic [31:0] minor;
		logic [63:0] re;
		logic [63:0] im;
		logic        last;
	} sparse_entry_t;

	typedef struct {
		logic [31:0] major;
		logic [31:0] minor;
		logic [63:0] re;
		logic [63:0] im;
		logic        last;
		logic        overflow;
	} sorted_entry_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic         cfg_data = ssks_pkg::MODE_MINOR;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [191:0] s_tdata = '0;    // major, minor, real, imag
	logic         s_tlast = 1'b0;  // last
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [191:0] m_tdata;         // major, minor, real, imag
	logic         m_tlast;         // last sorted entry
	logic         m_tuser;         // overflow

	sparse_segment_key_sorter #(
		.MAX_ENTRIES(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// bench copy of the segment store and key mode
	sparse_entry_t seg_store[DEPTH];
	int unsigned   seg_count = 0;
	logic          seg_dropped = 1'b0;
	logic          key_mode_copy = ssks_pkg::MODE_MINOR;

	sparse_entry_t entry_q[$];
	sorted_entry_t sorted_q[$];
	int unsigned   fail_count = 0;
	int unsigned   cycle_count = 0;

	function automatic logic sorts_after(sparse_entry_t a, sparse_entry_t b);
		if ((key_mode_copy == ssks_pkg::MODE_MAJOR_MINOR) && (a.major != b.major)) begin
			return a.major > b.major;
		end
		return a.minor > b.minor;
	endfunction

	// store or drop one entry; on the last one queue the stably sorted segment
	task automatic absorb_entry(input sparse_entry_t e);
		sparse_entry_t run[DEPTH];
		sparse_entry_t t;
		sorted_entry_t r;
		int j;
		if (seg_count < DEPTH) begin
			seg_store[seg_count] = e;
			seg_count++;
		end else begin
			seg_dropped = 1'b1;
		end
		if (e.last) begin
			run = seg_store;
			for (int i = 1; i < int'(seg_count); i++) begin
				j = i;
				while (j > 0 && sorts_after(run[j-1], run[j])) begin
					t = run[j-1];
					run[j-1] = run[j];
					run[j] = t;
					j--;
				end
			end
			for (int k = 0; k < int'(seg_count); k++) begin
				r.major = run[k].major;
				r.minor = run[k].minor;
				r.re = run[k].re;
				r.im = run[k].im;
				r.last = (k == int'(seg_count) - 1);
				r.overflow = seg_dropped;
				sorted_q.push_back(r);
			end
			seg_count = 0;
			seg_dropped = 1'b0;
		end
	endtask

	// driver: bursts of random length, sometimes separated by random gaps
	sparse_entry_t in_flight;
	int unsigned   burst_left = 0;
	int unsigned   gap_left = 0;

	always @(posedge clk) begin
		if (arst_n && !(s_tvalid && !s_tready)) begin
			if (s_tvalid) begin
				absorb_entry(in_flight);
			end
			if (gap_left != 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (entry_q.size() != 0) begin
				in_flight = entry_q.pop_front();
				s_tdata <= {in_flight.im, in_flight.re, in_flight.minor, in_flight.major};
				s_tlast <= in_flight.last;
				s_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
				end else begin
					burst_left--;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	task automatic report_field(input string field, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			fail_count++;
		end
	endtask

	task automatic check_sorted_entry();
		sorted_entry_t want;
		if (sorted_q.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual tdata %h tlast %b tuser %b",
				$time, m_tdata, m_tlast, m_tuser);
			fail_count++;
		end else begin
			want = sorted_q.pop_front();
			report_field("major", 64'(want.major), 64'(m_tdata[31:0]));
			report_field("minor", 64'(want.minor), 64'(m_tdata[63:32]));
			report_field("real", want.re, m_tdata[127:64]);
			report_field("imag", want.im, m_tdata[191:128]);
			report_field("last", 64'(want.last), 64'(m_tlast));
			report_field("overflow", 64'(want.overflow), 64'(m_tuser));
		end
	endtask

	// monitor: receiver stalls follow a 16-bit ready pattern redrawn each round
	logic [15:0] ready_pattern = '1;
	int unsigned pattern_pos = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				check_sorted_entry();
			end
			m_tready <= ready_pattern[pattern_pos];
			if (pattern_pos == 15) begin
				pattern_pos = 0;
				case ($urandom_range(0, 3))
					0: ready_pattern = '1;
					1: ready_pattern = 16'($urandom);
					2: ready_pattern = 16'($urandom | $urandom);
					default: ready_pattern = 16'(($urandom & $urandom) | 32'h0001);
				endcase
			end else begin
				pattern_pos++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic write_key_mode(input logic mode);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= mode;
		do @(posedge clk); while (!cfg_ready);
		key_mode_copy = mode;
		cfg_valid <= 1'b0;
	endtask

	// hold off until every sorted entry is out and the chain has settled
	task automatic wait_idle();
		do @(negedge clk); while (entry_q.size() != 0 || s_tvalid || sorted_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic push_entry(input logic [31:0] major, input logic [31:0] minor,
		input logic [63:0] re, input logic [63:0] im, input logic last);
		entry_q.push_back('{major, minor, re, im, last});
	endtask

	function automatic logic [31:0] pick_index(input int unsigned kind);
		case (kind)
			0: return $urandom_range(0, 3);
			1: return $urandom;
			default: return ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 2)
				: $urandom_range(0, 2);
		endcase
	endfunction

	task automatic add_segment(input int unsigned len, input int unsigned kind,
		input logic close);
		logic [63:0] im;
		for (int k = 0; k < int'(len); k++) begin
			// real matrices carry a zero imaginary word
			im = ($urandom_range(0, 3) == 0) ? 64'd0 : {$urandom, $urandom};
			push_entry(pick_index(kind), pick_index(kind), {$urandom, $urandom}, im,
				close && (k == int'(len) - 1));
		end
	endtask

	initial begin
		int unsigned phase_items;
		int unsigned len;
		logic        close;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// minor key only: extremes, ties kept in arrival order
		write_key_mode(ssks_pkg::MODE_MINOR);
		push_entry(32'h0, 32'hFFFF_FFFF, '1, 64'h0, 1'b0);
		push_entry(32'hFFFF_FFFF, 32'h0, 64'h0, '1, 1'b0);
		push_entry(32'd1, 32'd7, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		push_entry(32'd2, 32'd7, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0);
		push_entry(32'd3, 32'h0, 64'd1, 64'd2, 1'b1);
		// one-entry segment
		push_entry('1, '1, '1, '1, 1'b1);
		wait_idle();

		// major then minor, ties on both keys
		write_key_mode(ssks_pkg::MODE_MAJOR_MINOR);
		push_entry(32'd3, 32'd9, 64'd10, 64'd0, 1'b0);
		push_entry(32'd1, 32'd9, 64'd11, 64'd0, 1'b0);
		push_entry(32'd3, 32'd2, 64'd12, 64'd1, 1'b0);
		push_entry(32'd1, 32'd9, 64'd13, 64'd2, 1'b0);
		push_entry(32'hFFFF_FFFF, 32'h0, 64'd14, 64'd3, 1'b0);
		push_entry(32'h0, 32'hFFFF_FFFF, 64'd15, 64'd4, 1'b1);
		wait_idle();

		// mode changed while a segment is held: the mode at segment end decides
		push_entry(32'd5, 32'd1, 64'd20, 64'd0, 1'b0);
		push_entry(32'd4, 32'd2, 64'd21, 64'd0, 1'b0);
		push_entry(32'd3, 32'd3, 64'd22, 64'd0, 1'b0);
		wait_idle();
		write_key_mode(ssks_pkg::MODE_MINOR);
		push_entry(32'd2, 32'd4, 64'd23, 64'd0, 1'b0);
		push_entry(32'd1, 32'd0, 64'd24, 64'd0, 1'b1);
		push_entry(32'd9, 32'd0, 64'd30, 64'd5, 1'b0);
		push_entry(32'd8, 32'd5, 64'd31, 64'd6, 1'b0);
		push_entry(32'd7, 32'd5, 64'd32, 64'd7, 1'b0);
		wait_idle();
		write_key_mode(ssks_pkg::MODE_MAJOR_MINOR);
		push_entry(32'd6, 32'd1, 64'd33, 64'd8, 1'b1);
		wait_idle();

		// full store exactly, then a segment whose tail (last included) is dropped
		add_segment(DEPTH, 0, 1'b1);
		wait_idle();
		write_key_mode(ssks_pkg::MODE_MINOR);
		add_segment(DEPTH + 2, 0, 1'b1);
		wait_idle();

		// random segments; a phase may end with a segment still open
		for (int phase = 0; phase < int'(RANDOM_PHASES); phase++) begin
			write_key_mode((phase < 2) ? phase[0] : logic'($urandom_range(0, 1)));
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 32)
					: $urandom_range(1, 10);
				phase_items += len;
				close = (phase_items < PHASE_ITEMS) || (phase == int'(RANDOM_PHASES) - 1)
					|| ($urandom_range(0, 2) != 0);
				add_segment(len, $urandom_range(0, 2), close);
			end
			wait_idle();
		end

		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/ssks_pkg.sv
rtl/core/ssks_cell.sv
rtl/core/sparse_segment_key_sorter.sv
test/sparse_segment_key_sorter_tb.sv
